FILE: rtl/core/lupmi_pkg.sv
// Shared types and constants for the LU pivot matrix inverter.
// Used by lupmi_dp, lupmi_ctrl and lu_pivot_matrix_inverter; depends on nothing.
`timescale 1ns / 1ps

package lupmi_pkg;

  localparam int IDX_W  = 3;
  localparam int CNT_W  = 4;
  localparam int DATA_W = 32;
  localparam int TOL_W  = 16;
  localparam int SIZE_W = 4;
  localparam int ROWS   = 8;

  // Configuration register indexes.
  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_TOL  = 1'b1;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_WRITE_IN,
    DP_WR_X,
    DP_WR_A,
    DP_WR_RD,
    DP_A_RD,
    DP_A_X,
    DP_B_RD,
    DP_B_SC,
    DP_X_RD,
    DP_X_SC,
    DP_X_UNIT,
    DP_MUL1,
    DP_MUL2,
    DP_DIV_GO,
    DP_SC_WR,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_PERM_INIT,
    DP_PERM_SWAP,
    DP_EMIT,
    DP_EMIT_SING
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] rrow;
    logic [IDX_W-1:0] rcol;
    logic [IDX_W-1:0] wrow;
    logic [IDX_W-1:0] wcol;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] col;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] imax;
    logic             below_tol;
    logic             max_zero;
    logic             rd_zero;
    logic             div_busy;
  } dp_status_t;

  typedef enum logic [5:0] {
    S_IDLE, S_INIT, S_SCAN_INIT, S_SCAN, S_SCAN_CHK,
    S_SWAP_RA, S_SWAP_RB, S_SWAP_W1, S_SWAP_W2, S_SWAP_PERM,
    S_EL_RA, S_EL_RB, S_EL_B, S_EL_DGO, S_EL_DW, S_EL_WF, S_EL_AF,
    S_EL_KA, S_EL_KB, S_EL_KC, S_EL_KW,
    S_MUL1, S_MUL2, S_NEXT_COL, S_DIAG_RA, S_DIAG_CHK,
    S_FW_INIT, S_FW_RA, S_FW_RB, S_FW_SB, S_FW_WR,
    S_BK_INIT, S_BK_RA, S_BK_RB, S_BK_SB,
    S_BK_DRA, S_BK_DB, S_BK_DGO, S_BK_DW, S_BK_WR,
    S_EMIT, S_SING
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_EL,
    PH_FW,
    PH_BK
  } mul_phase_t;

endpackage

FILE: rtl/core/lupmi_dp.sv
// Datapath of the LU pivot matrix inverter: matrix memory, operand registers,
// multiply-subtract unit, bit-serial divider, permutation and result registers.
// Depends on lupmi_pkg.
`timescale 1ns / 1ps

module lupmi_dp #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lupmi_pkg::dp_cmd_t               cmd,
  input  logic signed [lupmi_pkg::DATA_W-1:0] matrix_entry,
  input  logic [lupmi_pkg::TOL_W-1:0]      pivot_tolerance,
  output lupmi_pkg::dp_status_t            status,
  output logic                             result_valid,
  output logic signed [lupmi_pkg::DATA_W-1:0] inverse_entry,
  output logic [2:0]                       row_index,
  output logic [2:0]                       column_index,
  output logic                             singular,
  output logic                             last_result
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = 34 + FRAC_BITS;
  localparam int DCW   = $clog2(DW + 1);
  localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd;
  logic signed [31:0] a, b, x;
  logic signed [31:0] sc [lupmi_pkg::ROWS];
  logic [2:0]         perm [lupmi_pkg::ROWS];
  logic [31:0]        maxmag;
  logic [2:0]         imax;
  logic [63:0]        prod;
  logic               pneg;

  logic               div_busy;
  logic [DCW-1:0]     dcnt;
  logic [DW-1:0]      dsh;
  logic [DW-1:0]      quo;
  logic [32:0]        rem;
  logic [32:0]        dvs;
  logic               dneg;

  logic [AW-1:0]      raddr, waddr;
  logic signed [31:0] wdata;
  logic [31:0]        mag_a, mag_b, mag_x, mag_rd;
  logic [63:0]        rnd;
  logic signed [63:0] diff;
  logic signed [31:0] mulsub;
  logic [33:0]        trial;
  logic               qbit;
  logic signed [31:0] qsat;
  logic signed [31:0] sc_rd;

  assign raddr = AW'(32'(cmd.rrow) * MAX_ORDER + 32'(cmd.rcol));
  assign waddr = AW'(32'(cmd.wrow) * MAX_ORDER + 32'(cmd.wcol));
  assign sc_rd = sc[cmd.idx];

  // Magnitudes of the operands.
  always_comb begin
    mag_a  = a[31]  ? 32'(-{1'b1, a})  : 32'(a);
    mag_b  = b[31]  ? 32'(-{1'b1, b})  : 32'(b);
    mag_x  = x[31]  ? 32'(-{1'b1, x})  : 32'(x);
    mag_rd = rd[31] ? 32'(-{1'b1, rd}) : 32'(rd);
  end

  // Second multiply stage: round, subtract from x and saturate.
  always_comb begin
    rnd  = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    diff = 64'(x) - (pneg ? -$signed(rnd) : $signed(rnd));
    if (diff > 64'(SAT_MAX)) begin
      mulsub = SAT_MAX;
    end else if (diff < 64'(SAT_MIN)) begin
      mulsub = SAT_MIN;
    end else begin
      mulsub = diff[31:0];
    end
  end

  // One restoring step of the divider, and saturation of the final quotient.
  always_comb begin
    trial = {rem, dsh[DW-1]};
    qbit  = (trial >= {1'b0, dvs});
    if (dneg) begin
      qsat = (quo >= DW'(64'h80000000)) ? SAT_MIN : -$signed(quo[31:0]);
    end else begin
      qsat = (quo >= DW'(64'h80000000)) ? SAT_MAX : $signed(quo[31:0]);
    end
  end

  // Matrix memory: one write port, one registered read port.
  always_comb begin
    case (cmd.op)
      lupmi_pkg::DP_WRITE_IN: wdata = matrix_entry;
      lupmi_pkg::DP_WR_A:     wdata = a;
      lupmi_pkg::DP_WR_RD:    wdata = rd;
      default:                wdata = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op inside {lupmi_pkg::DP_WRITE_IN, lupmi_pkg::DP_WR_X,
                       lupmi_pkg::DP_WR_A, lupmi_pkg::DP_WR_RD}) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  // Operand registers, multiplier and solution column.
  always_ff @(posedge clk) begin
    case (cmd.op)
      lupmi_pkg::DP_A_RD:   a <= rd;
      lupmi_pkg::DP_A_X:    a <= x;
      lupmi_pkg::DP_B_RD:   b <= rd;
      lupmi_pkg::DP_B_SC:   b <= sc_rd;
      lupmi_pkg::DP_X_RD:   x <= rd;
      lupmi_pkg::DP_X_SC:   x <= sc_rd;
      lupmi_pkg::DP_X_UNIT: x <= (perm[cmd.idx] == cmd.col) ? ONE : 32'sd0;
      lupmi_pkg::DP_MUL1: begin
        prod <= 64'(mag_a) * 64'(mag_b);
        pneg <= a[31] ^ b[31];
      end
      lupmi_pkg::DP_MUL2:   x <= mulsub;
      lupmi_pkg::DP_SC_WR:  sc[cmd.idx] <= x;
      default: begin
      end
    endcase
    if (div_busy && dcnt == '0) begin
      x <= qsat;
    end
  end

  // Bit-serial divider: x <= round(x / b) with one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.op == lupmi_pkg::DP_DIV_GO) begin
      div_busy <= 1'b1;
      dcnt     <= DCW'(DW);
      dsh      <= DW'({mag_x, {FRAC_BITS{1'b0}}, 1'b0}) + DW'(mag_b);
      dvs      <= {mag_b, 1'b0};
      rem      <= '0;
      quo      <= '0;
      dneg     <= x[31] ^ b[31];
    end else if (div_busy) begin
      if (dcnt == '0) begin
        div_busy <= 1'b0;
      end else begin
        rem  <= qbit ? 33'(trial - {1'b0, dvs}) : trial[32:0];
        dsh  <= dsh << 1;
        quo  <= {quo[DW-2:0], qbit};
        dcnt <= dcnt - 1'b1;
      end
    end
  end

  // Pivot search and row permutation.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lupmi_pkg::ROWS; i++) begin
        perm[i] <= 3'(i);
      end
    end else begin
      case (cmd.op)
        lupmi_pkg::DP_SCAN_INIT: begin
          maxmag <= '0;
          imax   <= cmd.col;
        end
        lupmi_pkg::DP_SCAN: begin
          if (mag_rd > maxmag) begin
            maxmag <= mag_rd;
            imax   <= cmd.idx;
          end
        end
        lupmi_pkg::DP_PERM_INIT: begin
          for (int i = 0; i < lupmi_pkg::ROWS; i++) begin
            perm[i] <= 3'(i);
          end
        end
        lupmi_pkg::DP_PERM_SWAP: begin
          perm[cmd.col] <= perm[imax];
          perm[imax]    <= perm[cmd.col];
        end
        default: begin
        end
      endcase
    end
  end

  // Result registers: each result shows for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == lupmi_pkg::DP_EMIT) || (cmd.op == lupmi_pkg::DP_EMIT_SING);
    end
    if (cmd.op == lupmi_pkg::DP_EMIT) begin
      inverse_entry <= sc_rd;
      row_index     <= cmd.idx;
      column_index  <= cmd.col;
      singular      <= 1'b0;
      last_result   <= cmd.last;
    end else if (cmd.op == lupmi_pkg::DP_EMIT_SING) begin
      inverse_entry <= '0;
      row_index     <= '0;
      column_index  <= '0;
      singular      <= 1'b1;
      last_result   <= 1'b1;
    end
  end

  assign status.imax      = imax;
  assign status.below_tol = (maxmag < 32'(pivot_tolerance));
  assign status.max_zero  = (maxmag == '0);
  assign status.rd_zero   = (rd == 32'sd0);
  assign status.div_busy  = div_busy;

endmodule

FILE: rtl/core/lupmi_ctrl.sv
// Controller of the LU pivot matrix inverter: loop counters and the state
// machine that sequences loading, factoring, solving and emitting.
// Depends on lupmi_pkg.
`timescale 1ns / 1ps

module lupmi_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            load_clear,
  input  logic [lupmi_pkg::SIZE_W-1:0]    n,
  input  lupmi_pkg::dp_status_t           status,
  output logic                            busy,
  output lupmi_pkg::dp_cmd_t              cmd
);

  lupmi_pkg::ctrl_state_t state, state_next;
  lupmi_pkg::mul_phase_t  phase, phase_next;
  logic [lupmi_pkg::CNT_W-1:0] lrow, lrow_next, lcol, lcol_next;
  logic [lupmi_pkg::CNT_W-1:0] col, col_next, row, row_next, kk, kk_next;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lupmi_pkg::S_IDLE;
      phase <= lupmi_pkg::PH_EL;
      lrow  <= '0;
      lcol  <= '0;
      col   <= '0;
      row   <= '0;
      kk    <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      lrow  <= lrow_next;
      lcol  <= lcol_next;
      col   <= col_next;
      row   <= row_next;
      kk    <= kk_next;
    end
  end

  assign busy = (state != lupmi_pkg::S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    phase_next = phase;
    lrow_next  = lrow;
    lcol_next  = lcol;
    col_next   = col;
    row_next   = row;
    kk_next    = kk;
    cmd        = '0;
    cmd.op     = lupmi_pkg::DP_NOP;

    case (state)
      lupmi_pkg::S_IDLE: begin
        if (load_clear) begin
          lrow_next = '0;
          lcol_next = '0;
        end else if (start) begin
          cmd.op   = lupmi_pkg::DP_WRITE_IN;
          cmd.wrow = lrow[2:0];
          cmd.wcol = lcol[2:0];
          if (lcol + 1'b1 >= n) begin
            lcol_next = '0;
            if (lrow + 1'b1 >= n) begin
              lrow_next  = '0;
              state_next = lupmi_pkg::S_INIT;
            end else begin
              lrow_next = lrow + 1'b1;
            end
          end else begin
            lcol_next = lcol + 1'b1;
          end
        end
      end

      lupmi_pkg::S_INIT: begin
        cmd.op     = lupmi_pkg::DP_PERM_INIT;
        col_next   = '0;
        state_next = lupmi_pkg::S_SCAN_INIT;
      end

      // Pivot search down the current column.
      lupmi_pkg::S_SCAN_INIT: begin
        cmd.op     = lupmi_pkg::DP_SCAN_INIT;
        cmd.col    = col[2:0];
        cmd.rrow   = col[2:0];
        cmd.rcol   = col[2:0];
        row_next   = col;
        state_next = lupmi_pkg::S_SCAN;
      end

      lupmi_pkg::S_SCAN: begin
        cmd.op   = lupmi_pkg::DP_SCAN;
        cmd.idx  = row[2:0];
        cmd.rrow = 3'(row + 1'b1);
        cmd.rcol = col[2:0];
        row_next = row + 1'b1;
        if (row + 1'b1 >= n) begin
          state_next = lupmi_pkg::S_SCAN_CHK;
        end
      end

      lupmi_pkg::S_SCAN_CHK: begin
        if (status.below_tol) begin
          state_next = lupmi_pkg::S_SING;
        end else if (status.imax != col[2:0]) begin
          kk_next    = '0;
          state_next = lupmi_pkg::S_SWAP_RA;
        end else if (status.max_zero) begin
          state_next = lupmi_pkg::S_NEXT_COL;
        end else begin
          row_next   = col + 1'b1;
          state_next = lupmi_pkg::S_EL_RA;
        end
      end

      // Row exchange, one entry at a time.
      lupmi_pkg::S_SWAP_RA: begin
        cmd.rrow   = col[2:0];
        cmd.rcol   = kk[2:0];
        state_next = lupmi_pkg::S_SWAP_RB;
      end

      lupmi_pkg::S_SWAP_RB: begin
        cmd.op     = lupmi_pkg::DP_A_RD;
        cmd.rrow   = status.imax;
        cmd.rcol   = kk[2:0];
        state_next = lupmi_pkg::S_SWAP_W1;
      end

      lupmi_pkg::S_SWAP_W1: begin
        cmd.op     = lupmi_pkg::DP_WR_RD;
        cmd.wrow   = col[2:0];
        cmd.wcol   = kk[2:0];
        state_next = lupmi_pkg::S_SWAP_W2;
      end

      lupmi_pkg::S_SWAP_W2: begin
        cmd.op   = lupmi_pkg::DP_WR_A;
        cmd.wrow = status.imax;
        cmd.wcol = kk[2:0];
        kk_next  = kk + 1'b1;
        if (kk + 1'b1 < n) begin
          state_next = lupmi_pkg::S_SWAP_RA;
        end else begin
          state_next = lupmi_pkg::S_SWAP_PERM;
        end
      end

      lupmi_pkg::S_SWAP_PERM: begin
        cmd.op  = lupmi_pkg::DP_PERM_SWAP;
        cmd.col = col[2:0];
        if (status.max_zero) begin
          state_next = lupmi_pkg::S_NEXT_COL;
        end else begin
          row_next   = col + 1'b1;
          state_next = lupmi_pkg::S_EL_RA;
        end
      end

      // Elimination: multiplier of row 'row', then update of its tail.
      lupmi_pkg::S_EL_RA: begin
        cmd.rrow   = row[2:0];
        cmd.rcol   = col[2:0];
        state_next = lupmi_pkg::S_EL_RB;
      end

      lupmi_pkg::S_EL_RB: begin
        cmd.op     = lupmi_pkg::DP_X_RD;
        cmd.rrow   = col[2:0];
        cmd.rcol   = col[2:0];
        state_next = lupmi_pkg::S_EL_B;
      end

      lupmi_pkg::S_EL_B: begin
        cmd.op     = lupmi_pkg::DP_B_RD;
        state_next = lupmi_pkg::S_EL_DGO;
      end

      lupmi_pkg::S_EL_DGO: begin
        cmd.op     = lupmi_pkg::DP_DIV_GO;
        state_next = lupmi_pkg::S_EL_DW;
      end

      lupmi_pkg::S_EL_DW: begin
        if (!status.div_busy) begin
          state_next = lupmi_pkg::S_EL_WF;
        end
      end

      lupmi_pkg::S_EL_WF: begin
        cmd.op     = lupmi_pkg::DP_WR_X;
        cmd.wrow   = row[2:0];
        cmd.wcol   = col[2:0];
        state_next = lupmi_pkg::S_EL_AF;
      end

      lupmi_pkg::S_EL_AF: begin
        cmd.op     = lupmi_pkg::DP_A_X;
        kk_next    = col + 1'b1;
        state_next = lupmi_pkg::S_EL_KA;
      end

      lupmi_pkg::S_EL_KA: begin
        cmd.rrow   = row[2:0];
        cmd.rcol   = kk[2:0];
        state_next = lupmi_pkg::S_EL_KB;
      end

      lupmi_pkg::S_EL_KB: begin
        cmd.op     = lupmi_pkg::DP_X_RD;
        cmd.rrow   = col[2:0];
        cmd.rcol   = kk[2:0];
        state_next = lupmi_pkg::S_EL_KC;
      end

      lupmi_pkg::S_EL_KC: begin
        cmd.op     = lupmi_pkg::DP_B_RD;
        phase_next = lupmi_pkg::PH_EL;
        state_next = lupmi_pkg::S_MUL1;
      end

      lupmi_pkg::S_EL_KW: begin
        cmd.op   = lupmi_pkg::DP_WR_X;
        cmd.wrow = row[2:0];
        cmd.wcol = kk[2:0];
        kk_next  = kk + 1'b1;
        if (kk + 1'b1 < n) begin
          state_next = lupmi_pkg::S_EL_KA;
        end else if (row + 1'b1 < n) begin
          row_next   = row + 1'b1;
          state_next = lupmi_pkg::S_EL_RA;
        end else begin
          state_next = lupmi_pkg::S_NEXT_COL;
        end
      end

      // Shared multiply-subtract, returning to the loop that called it.
      lupmi_pkg::S_MUL1: begin
        cmd.op     = lupmi_pkg::DP_MUL1;
        state_next = lupmi_pkg::S_MUL2;
      end

      lupmi_pkg::S_MUL2: begin
        cmd.op = lupmi_pkg::DP_MUL2;
        case (phase)
          lupmi_pkg::PH_EL: begin
            state_next = lupmi_pkg::S_EL_KW;
          end
          lupmi_pkg::PH_FW: begin
            kk_next    = kk + 1'b1;
            state_next = (kk + 1'b1 < row) ? lupmi_pkg::S_FW_RA : lupmi_pkg::S_FW_WR;
          end
          default: begin
            kk_next    = kk + 1'b1;
            state_next = (kk + 1'b1 < n) ? lupmi_pkg::S_BK_RA : lupmi_pkg::S_BK_DRA;
          end
        endcase
      end

      lupmi_pkg::S_NEXT_COL: begin
        col_next = col + 1'b1;
        if (col + 2'd2 < n) begin
          state_next = lupmi_pkg::S_SCAN_INIT;
        end else begin
          row_next   = '0;
          state_next = lupmi_pkg::S_DIAG_RA;
        end
      end

      // A zero on the diagonal of U means the matrix is singular.
      lupmi_pkg::S_DIAG_RA: begin
        cmd.rrow   = row[2:0];
        cmd.rcol   = row[2:0];
        state_next = lupmi_pkg::S_DIAG_CHK;
      end

      lupmi_pkg::S_DIAG_CHK: begin
        if (status.rd_zero) begin
          state_next = lupmi_pkg::S_SING;
        end else if (row + 1'b1 < n) begin
          row_next   = row + 1'b1;
          state_next = lupmi_pkg::S_DIAG_RA;
        end else begin
          row_next   = '0;
          col_next   = '0;
          state_next = lupmi_pkg::S_FW_INIT;
        end
      end

      // Forward substitution on the permuted unit column 'col'.
      lupmi_pkg::S_FW_INIT: begin
        cmd.op     = lupmi_pkg::DP_X_UNIT;
        cmd.idx    = row[2:0];
        cmd.col    = col[2:0];
        kk_next    = '0;
        state_next = (row == '0) ? lupmi_pkg::S_FW_WR : lupmi_pkg::S_FW_RA;
      end

      lupmi_pkg::S_FW_RA: begin
        cmd.rrow   = row[2:0];
        cmd.rcol   = kk[2:0];
        state_next = lupmi_pkg::S_FW_RB;
      end

      lupmi_pkg::S_FW_RB: begin
        cmd.op     = lupmi_pkg::DP_A_RD;
        state_next = lupmi_pkg::S_FW_SB;
      end

      lupmi_pkg::S_FW_SB: begin
        cmd.op     = lupmi_pkg::DP_B_SC;
        cmd.idx    = kk[2:0];
        phase_next = lupmi_pkg::PH_FW;
        state_next = lupmi_pkg::S_MUL1;
      end

      lupmi_pkg::S_FW_WR: begin
        cmd.op  = lupmi_pkg::DP_SC_WR;
        cmd.idx = row[2:0];
        if (row + 1'b1 < n) begin
          row_next   = row + 1'b1;
          state_next = lupmi_pkg::S_FW_INIT;
        end else begin
          row_next   = n - 1'b1;
          state_next = lupmi_pkg::S_BK_INIT;
        end
      end

      // Back substitution, last row first.
      lupmi_pkg::S_BK_INIT: begin
        cmd.op     = lupmi_pkg::DP_X_SC;
        cmd.idx    = row[2:0];
        kk_next    = row + 1'b1;
        state_next = (row + 1'b1 < n) ? lupmi_pkg::S_BK_RA : lupmi_pkg::S_BK_DRA;
      end

      lupmi_pkg::S_BK_RA: begin
        cmd.rrow   = row[2:0];
        cmd.rcol   = kk[2:0];
        state_next = lupmi_pkg::S_BK_RB;
      end

      lupmi_pkg::S_BK_RB: begin
        cmd.op     = lupmi_pkg::DP_A_RD;
        state_next = lupmi_pkg::S_BK_SB;
      end

      lupmi_pkg::S_BK_SB: begin
        cmd.op     = lupmi_pkg::DP_B_SC;
        cmd.idx    = kk[2:0];
        phase_next = lupmi_pkg::PH_BK;
        state_next = lupmi_pkg::S_MUL1;
      end

      lupmi_pkg::S_BK_DRA: begin
        cmd.rrow   = row[2:0];
        cmd.rcol   = row[2:0];
        state_next = lupmi_pkg::S_BK_DB;
      end

      lupmi_pkg::S_BK_DB: begin
        cmd.op     = lupmi_pkg::DP_B_RD;
        state_next = lupmi_pkg::S_BK_DGO;
      end

      lupmi_pkg::S_BK_DGO: begin
        cmd.op     = lupmi_pkg::DP_DIV_GO;
        state_next = lupmi_pkg::S_BK_DW;
      end

      lupmi_pkg::S_BK_DW: begin
        if (!status.div_busy) begin
          state_next = lupmi_pkg::S_BK_WR;
        end
      end

      lupmi_pkg::S_BK_WR: begin
        cmd.op  = lupmi_pkg::DP_SC_WR;
        cmd.idx = row[2:0];
        if (row == '0) begin
          state_next = lupmi_pkg::S_EMIT;
        end else begin
          row_next   = row - 1'b1;
          state_next = lupmi_pkg::S_BK_INIT;
        end
      end

      // Emit the finished column, rows in ascending order.
      lupmi_pkg::S_EMIT: begin
        cmd.op   = lupmi_pkg::DP_EMIT;
        cmd.idx  = row[2:0];
        cmd.col  = col[2:0];
        cmd.last = (row + 1'b1 == n) && (col + 1'b1 == n);
        if (row + 1'b1 < n) begin
          row_next = row + 1'b1;
        end else begin
          row_next = '0;
          if (col + 1'b1 < n) begin
            col_next   = col + 1'b1;
            state_next = lupmi_pkg::S_FW_INIT;
          end else begin
            state_next = lupmi_pkg::S_IDLE;
          end
        end
      end

      lupmi_pkg::S_SING: begin
        cmd.op     = lupmi_pkg::DP_EMIT_SING;
        state_next = lupmi_pkg::S_IDLE;
      end

      default: begin
        state_next = lupmi_pkg::S_IDLE;
      end
    endcase
  end

  // While the controller is idle, the datapath gets no command but input writes.
  a_idle_ops: assert property (@(posedge clk) disable iff (rst)
    (state == lupmi_pkg::S_IDLE) |->
      (cmd.op == lupmi_pkg::DP_NOP || cmd.op == lupmi_pkg::DP_WRITE_IN))
    else $error("datapath command issued while idle");

  // No division may still be running once the controller has gone idle.
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == lupmi_pkg::S_IDLE) |-> !status.div_busy)
    else $error("divider busy while idle");

  // Emitted rows and columns stay inside the matrix order.
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == lupmi_pkg::S_EMIT) |-> (row < n && col < n))
    else $error("emitted index beyond matrix order");

  // A singular verdict ends the run.
  a_sing_end: assert property (@(posedge clk) disable iff (rst)
    (state == lupmi_pkg::S_SING) |=> (state == lupmi_pkg::S_IDLE))
    else $error("run continued after singular result");

endmodule

FILE: rtl/core/lu_pivot_matrix_inverter.sv
// Top level of the LU pivot matrix inverter: configuration registers and the
// controller and datapath. Depends on lupmi_pkg, lupmi_ctrl and lupmi_dp.
`timescale 1ns / 1ps

// Loads an n by n signed fixed-point matrix one item per start pulse, row by
// row, then factors it with partial pivoting and emits the inverse column by
// column, one item per cycle on result_valid within a column, or a single
// singular item. The receiver cannot stall: every result is valid for exactly
// one cycle. Once loading ends, busy stays high for the whole computation.
// Its length is set by the shared bit-serial divider, which is used up to
// n(n-1)/2 + n*n times, by the shared multiply-subtract sequence (roughly
// n^3 steps of it), and by the emission of the n*n entries.
// Configuration writes are accepted at any time but must only be made while
// the block is idle.

module lu_pivot_matrix_inverter #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lupmi_pkg::DATA_W-1:0] matrix_entry,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [lupmi_pkg::TOL_W-1:0]         cfg_data,
  output logic                                result_valid,
  output logic signed [lupmi_pkg::DATA_W-1:0] inverse_entry,
  output logic [2:0]                          row_index,
  output logic [2:0]                          column_index,
  output logic                                singular,
  output logic                                last_result
);

  logic [lupmi_pkg::SIZE_W-1:0] matrix_size;
  logic [lupmi_pkg::TOL_W-1:0]  pivot_tolerance;
  logic [lupmi_pkg::SIZE_W-1:0] n;
  logic                         cfg_we;
  logic                         load_clear;
  lupmi_pkg::dp_cmd_t           cmd;
  lupmi_pkg::dp_status_t        status;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign load_clear = cfg_we && (cfg_index == lupmi_pkg::CFG_SIZE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size     <= 4'd8;
      pivot_tolerance <= 16'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        lupmi_pkg::CFG_SIZE: matrix_size     <= cfg_data[lupmi_pkg::SIZE_W-1:0];
        lupmi_pkg::CFG_TOL:  pivot_tolerance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Order in use, clamped to the supported range.
  always_comb begin
    if (matrix_size < 4'd2) begin
      n = 4'd2;
    end else if (matrix_size > lupmi_pkg::SIZE_W'(MAX_ORDER)) begin
      n = lupmi_pkg::SIZE_W'(MAX_ORDER);
    end else begin
      n = matrix_size;
    end
  end

  lupmi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .load_clear (load_clear),
    .n          (n),
    .status     (status),
    .busy       (busy),
    .cmd        (cmd)
  );

  lupmi_dp #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .matrix_entry    (matrix_entry),
    .pivot_tolerance (pivot_tolerance),
    .status          (status),
    .result_valid    (result_valid),
    .inverse_entry   (inverse_entry),
    .row_index       (row_index),
    .column_index    (column_index),
    .singular        (singular),
    .last_result     (last_result)
  );

endmodule
